// ===== sv/vhs_pkg.sv =====
// Shared types and constants for the VXLAN header strip block.
package vhs_pkg;

    localparam int OFF_W = 7;
    localparam logic [OFF_W-1:0] ETH_LEN    = 7'd14;
    localparam logic [OFF_W-1:0] OFFSET_CAP = 7'd90;
    localparam logic [OFF_W-1:0] SRC_FIRST  = 7'd26;
    localparam logic [OFF_W-1:0] SRC_LAST   = 7'd29;
    localparam logic [OFF_W-1:0] DST_FIRST  = 7'd30;
    localparam logic [OFF_W-1:0] DST_LAST   = 7'd33;
    // header total is HDR_BASE + 4*IHL; VNI occupies the 4th..2nd last header bytes
    localparam logic [OFF_W-1:0] HDR_BASE   = 7'd30;
    localparam logic [OFF_W-1:0] VNI_FIRST  = 7'd26;
    localparam logic [OFF_W-1:0] VNI_LAST   = 7'd28;
    localparam logic [OFF_W-1:0] HDR_END    = 7'd29;
    localparam logic [3:0]       IHL_MIN    = 4'd5;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_MALFORMED = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        end_of_packet;
        logic        meta_en;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [23:0] vni;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic   full;
        logic   empty;
        entry_t head;
    } q_status_t;

endpackage

// ===== sv/vhs_if.sv =====
// Valid/ready channel interfaces for frame bytes in and strip results out.
interface vhs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface vhs_out_if;
    logic            valid;
    logic            ready;
    vhs_pkg::kind_t  kind;
    logic [7:0]      payload_byte;
    logic            end_of_packet;
    logic [31:0]     outer_src_addr;
    logic [31:0]     outer_dst_addr;
    logic [23:0]     tunnel_vni;

    modport source (output valid, output kind, output payload_byte, output end_of_packet,
                    output outer_src_addr, output outer_dst_addr, output tunnel_vni,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input end_of_packet,
                    input outer_src_addr, input outer_dst_addr, input tunnel_vni,
                    output ready);
endinterface

// ===== sv/vxlan_header_strip.sv =====
// VXLAN header strip: one frame byte per transfer in, payload bytes with tunnel metadata out.
// A result byte is written into a queue slot on its input transfer, then loaded into the output
// register, and only then is it valid on the output and able to transfer out.
// Throughput: one byte per cycle, set by the single-byte classifier and one queue pop a cycle.
// The queue absorbs output stalls; input ready drops only when it holds QUEUE_DEPTH results.
// Reset (async, active low) clears offset, drop flag, captured metadata, queue and output valid.
module vxlan_header_strip #(
    parameter int QUEUE_DEPTH = vhs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    vhs_in_if.sink    frame,
    vhs_out_if.source result
);
    import vhs_pkg::*;

    q_push_t   push;
    q_status_t q_stat;
    logic      pop;

    vhs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .q_stat (q_stat),
        .push   (push)
    );

    vhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .q_stat (q_stat)
    );

    vhs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== sv/vhs_front.sv =====
// Front end: byte offset tracking, header capture and per-byte classification.
module vhs_front (
    input  logic               clk,
    input  logic               rst_n,
    vhs_in_if.sink             frame,
    input  vhs_pkg::q_status_t q_stat,
    output vhs_pkg::q_push_t   push
);
    import vhs_pkg::*;

    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [23:0]      vni_reg, vni_next;
    logic             drop_reg, drop_next;

    logic             accept;
    logic             is_ihl;
    logic [3:0]       ihl_now;
    logic             drop_now;
    logic [OFF_W-1:0] ihl_x4;
    logic [OFF_W-1:0] hdr;
    logic [OFF_W-1:0] off_inc;

    assign frame.ready = !q_stat.full;
    assign accept      = frame.valid && frame.ready;

    assign is_ihl   = !drop_reg && (offset_reg == ETH_LEN);
    assign ihl_now  = is_ihl ? frame.data_byte[3:0] : ihl_reg;
    assign drop_now = drop_reg || (is_ihl && (frame.data_byte[3:0] < IHL_MIN));
    assign ihl_x4   = {1'b0, ihl_now, 2'b00};
    assign hdr      = HDR_BASE + ihl_x4;
    assign off_inc  = (offset_reg < OFFSET_CAP) ? offset_reg + 7'd1 : OFFSET_CAP;

    always_comb
    begin
        offset_next = offset_reg;
        ihl_next    = ihl_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        vni_next    = vni_reg;
        drop_next   = drop_reg;
        push        = '0;
        push.entry.kind = KIND_MALFORMED;

        if (accept)
        begin
            ihl_next = ihl_now;
            if (drop_now || (offset_reg < ETH_LEN))
            begin
                if (frame.frame_end)
                begin
                    push.valid               = 1'b1;
                    push.entry.kind          = KIND_MALFORMED;
                    push.entry.end_of_packet = 1'b1;
                    offset_next              = '0;
                    drop_next                = 1'b0;
                end
                else
                begin
                    offset_next = off_inc;
                    drop_next   = drop_now;
                end
            end
            else if (offset_reg >= hdr)
            begin
                push.valid               = 1'b1;
                push.entry.kind          = KIND_PAYLOAD;
                push.entry.payload_byte  = frame.data_byte;
                push.entry.end_of_packet = frame.frame_end;
                push.entry.meta_en       = 1'b1;
                push.entry.src_addr      = src_reg;
                push.entry.dst_addr      = dst_reg;
                push.entry.vni           = vni_reg;
                offset_next              = frame.frame_end ? '0 : off_inc;
            end
            else
            begin
                if ((offset_reg >= SRC_FIRST) && (offset_reg <= SRC_LAST))
                    src_next = {src_reg[23:0], frame.data_byte};
                else if ((offset_reg >= DST_FIRST) && (offset_reg <= DST_LAST))
                    dst_next = {dst_reg[23:0], frame.data_byte};
                if ((offset_reg >= VNI_FIRST + ihl_x4) && (offset_reg <= VNI_LAST + ihl_x4))
                    vni_next = {vni_reg[15:0], frame.data_byte};

                if (frame.frame_end)
                begin
                    push.valid               = 1'b1;
                    push.entry.end_of_packet = 1'b1;
                    if (offset_reg == HDR_END + ihl_x4)
                    begin
                        // headers only: report empty with metadata
                        push.entry.kind     = KIND_EMPTY;
                        push.entry.meta_en  = 1'b1;
                        push.entry.src_addr = src_next;
                        push.entry.dst_addr = dst_next;
                        push.entry.vni      = vni_next;
                    end
                    else
                    begin
                        push.entry.kind = KIND_MALFORMED;
                    end
                    offset_next = '0;
                    drop_next   = 1'b0;
                end
                else
                begin
                    offset_next = off_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            ihl_reg    <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            vni_reg    <= '0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            ihl_reg    <= ihl_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            vni_reg    <= vni_next;
            drop_reg   <= drop_next;
        end
    end

`ifndef ASSERT_OFF
    a_offset_cap: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFFSET_CAP)
        else $error("byte offset beyond cap");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame.frame_end) |=> (offset_reg == '0) && !drop_reg)
        else $error("frame end did not clear offset/drop");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (accept && !q_stat.full))
        else $error("queue push without accepted byte");
`endif

endmodule

// ===== sv/vhs_queue.sv =====
// Small result queue between the classifier and the output stage.
module vhs_queue #(
    parameter int DEPTH = vhs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vhs_pkg::q_push_t    push,
    input  logic                pop,
    output vhs_pkg::q_status_t  q_stat
);
    import vhs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push.valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            slots_reg[wr_ptr_reg] <= push.entry;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count overflow");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_stat.full)
        else $error("push into full queue");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push.valid) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower count");
`endif

endmodule

// ===== sv/vhs_back.sv =====
// Back end: output register that drains the queue and formats results.
module vhs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  vhs_pkg::q_status_t q_stat,
    output logic               pop,
    vhs_out_if.source          result
);
    import vhs_pkg::*;

    logic        valid_reg;
    kind_t       kind_reg;
    logic [7:0]  byte_reg;
    logic        eop_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [23:0] vni_reg;

    // refill whenever the register is free or its transfer completes this cycle
    assign pop = !q_stat.empty && (!valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= q_stat.head.kind;
            byte_reg <= q_stat.head.payload_byte;
            eop_reg  <= q_stat.head.end_of_packet;
            src_reg  <= q_stat.head.meta_en ? q_stat.head.src_addr : '0;
            dst_reg  <= q_stat.head.meta_en ? q_stat.head.dst_addr : '0;
            vni_reg  <= q_stat.head.meta_en ? q_stat.head.vni : '0;
        end
    end

    assign result.valid          = valid_reg;
    assign result.kind           = kind_reg;
    assign result.payload_byte   = byte_reg;
    assign result.end_of_packet  = eop_reg;
    assign result.outer_src_addr = src_reg;
    assign result.outer_dst_addr = dst_reg;
    assign result.tunnel_vni     = vni_reg;

endmodule
